### rtl/lrupr_pkg.sv
// Shared types and fixed field widths for the LRU page replacement block.
// Used by the front, back and top modules of the block and by its checker.
package lrupr_pkg;

  localparam int PAGE_W      = 16;
  localparam int IDX_W       = 3;
  localparam int TOTAL_W     = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   frame_index;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] fault_total;
  } result_t;

endpackage

### rtl/lrupr_queue.sv
// Small first-in first-out queue of registers with push/full and pop/empty sides.
// Stands between the front and back parts and in front of the result ports.
module lrupr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

### rtl/lrupr_front.sv
// Input stage: registers each page reference, keeps only the tag bits in use,
// and hands it to the queue that feeds the replacement engine. Uses lrupr_pkg.
module lrupr_front
  import lrupr_pkg::*;
#(
  parameter int TAG_W = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [PAGE_W-1:0] page,
  output logic              q_push,
  input  logic              q_full,
  output logic [TAG_W-1:0]  q_page
);

  logic             held_valid;
  logic [TAG_W-1:0] held_page;
  logic             accept;

  // The held reference moves on whenever the queue has room, so a new
  // transaction can be taken in the same cycle.
  assign full   = held_valid && q_full;
  assign accept = push && !full;
  assign q_push = held_valid;
  assign q_page = held_page;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (!q_full) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_page <= page[TAG_W-1:0];
    end
  end

endmodule

### rtl/lrupr_back.sv
// Replacement engine: tag compare over all frames, fill or evict, rank update
// and saturating totals, one reference per cycle while a reference waits and the result queue has room. Uses lrupr_pkg.
module lrupr_back
  import lrupr_pkg::*;
#(
  parameter int FRAMES = 8,
  parameter int TAG_W  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_empty,
  input  logic [TAG_W-1:0] in_page,
  output logic             in_pop,
  input  logic             out_full,
  output logic             out_push,
  output result_t          out_result
);

  localparam int FW = $clog2(FRAMES);

  logic [TAG_W-1:0]   frame_page   [FRAMES];
  logic [FRAMES-1:0]  frame_valid;
  logic [FW-1:0]      recency_rank [FRAMES];
  logic [TOTAL_W-1:0] hit_count;
  logic [TOTAL_W-1:0] fault_count;

  logic [FRAMES-1:0]  frame_valid_next;
  logic [FW-1:0]      recency_rank_next [FRAMES];
  logic [TOTAL_W-1:0] hit_count_next;
  logic [TOTAL_W-1:0] fault_count_next;

  logic               go;
  logic               hit_any;
  logic               empty_any;
  logic [FW-1:0]      hit_idx;
  logic [FW-1:0]      empty_idx;
  logic [FW-1:0]      victim_idx;
  logic [FW-1:0]      used;
  logic [FW:0]        old_rank;
  logic               write_tag;

  assign go       = !in_empty && !out_full;
  assign in_pop   = go;
  assign out_push = go;

  always_comb begin
    hit_any    = 1'b0;
    empty_any  = 1'b0;
    hit_idx    = '0;
    empty_idx  = '0;
    victim_idx = '0;
    // Walk from the top so that the lowest-numbered frame wins.
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (frame_valid[i] && frame_page[i] == in_page) begin
        hit_any = 1'b1;
        hit_idx = FW'(i);
      end
      if (!frame_valid[i]) begin
        empty_any = 1'b1;
        empty_idx = FW'(i);
      end
      // With every frame valid the ranks are a permutation, so exactly one
      // frame holds the oldest rank.
      if (recency_rank[i] == FW'(FRAMES - 1)) begin
        victim_idx = FW'(i);
      end
    end
  end

  always_comb begin
    if (hit_any) begin
      used     = hit_idx;
      old_rank = {1'b0, recency_rank[hit_idx]};
    end else if (empty_any) begin
      used     = empty_idx;
      old_rank = (FW + 1)'(FRAMES);
    end else begin
      used     = victim_idx;
      old_rank = (FW + 1)'(FRAMES - 1);
    end
  end

  assign write_tag = go && !hit_any;

  always_comb begin
    frame_valid_next = frame_valid;
    for (int i = 0; i < FRAMES; i++) begin
      if (FW'(i) == used) begin
        recency_rank_next[i] = '0;
      end else if (frame_valid[i] && {1'b0, recency_rank[i]} < old_rank) begin
        recency_rank_next[i] = recency_rank[i] + 1'b1;
      end else begin
        recency_rank_next[i] = recency_rank[i];
      end
    end
    if (!hit_any) begin
      frame_valid_next[used] = 1'b1;
    end
    hit_count_next   = hit_count;
    fault_count_next = fault_count;
    if (hit_any) begin
      if (hit_count != '1) begin
        hit_count_next = hit_count + 1'b1;
      end
    end else if (fault_count != '1) begin
      fault_count_next = fault_count + 1'b1;
    end
  end

  always_comb begin
    out_result.hit           = hit_any;
    out_result.frame_index   = IDX_W'(used);
    out_result.evicted_valid = !hit_any && !empty_any;
    out_result.evicted_page  = (!hit_any && !empty_any) ?
                               PAGE_W'(frame_page[victim_idx]) : '0;
    out_result.hit_total     = hit_count_next;
    out_result.fault_total   = fault_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      hit_count   <= '0;
      fault_count <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        recency_rank[i] <= '0;
      end
    end else if (go) begin
      frame_valid  <= frame_valid_next;
      hit_count    <= hit_count_next;
      fault_count  <= fault_count_next;
      recency_rank <= recency_rank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (write_tag) begin
      frame_page[used] <= in_page;
    end
  end

endmodule

### rtl/lru_page_replacement.sv
// LRU page replacement block.
// Input side is a queue: drive page with push high while full is low; each
// such edge is one transaction, one page reference. Result side is a queue:
// while empty is low the oldest result sits on hit, frame_index,
// evicted_valid, evicted_page, hit_total and fault_total, and it is consumed
// at an edge where pop is high.
// Every reference yields exactly one result, in order. A reference passes
// through the input register, the queue in front of the engine and the
// result queue before its result shows on the ports. The engine compares
// the page against all frames and updates the ranks combinationally and
// writes the result queue at the edge where it pops the middle queue.
// Sustained throughput is one reference per cycle while pop drains results.
// When pop is held low the result queue fills, the engine stops, the middle
// queue and the input register fill, and full rises; nothing is lost.
// Reset (rst, synchronous) empties every frame, clears the ranks and both
// totals, and flushes all queues; no clearing pass is needed.
// Depends on lrupr_pkg, lrupr_front, lrupr_queue and lrupr_back.
module lru_page_replacement
  import lrupr_pkg::*;
#(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [PAGE_W-1:0]  page,
  output logic               empty,
  input  logic               pop,
  output logic               hit,
  output logic [IDX_W-1:0]   frame_index,
  output logic               evicted_valid,
  output logic [PAGE_W-1:0]  evicted_page,
  output logic [TOTAL_W-1:0] hit_total,
  output logic [TOTAL_W-1:0] fault_total
);

  // Only the page bits that fit the input port can ever be set.
  localparam int TAG_W = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;

  logic             mid_push;
  logic             mid_full;
  logic [TAG_W-1:0] mid_wdata;
  logic             mid_pop;
  logic             mid_empty;
  logic [TAG_W-1:0] mid_rdata;
  logic             res_push;
  logic             res_full;
  result_t          res_wdata;
  result_t          res_head;

  lrupr_front #(
    .TAG_W (TAG_W)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .page   (page),
    .q_push (mid_push),
    .q_full (mid_full),
    .q_page (mid_wdata)
  );

  lrupr_queue #(
    .WIDTH (TAG_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .full  (mid_full),
    .wdata (mid_wdata),
    .pop   (mid_pop),
    .empty (mid_empty),
    .rdata (mid_rdata)
  );

  lrupr_back #(
    .FRAMES (FRAMES),
    .TAG_W  (TAG_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_empty   (mid_empty),
    .in_page    (mid_rdata),
    .in_pop     (mid_pop),
    .out_full   (res_full),
    .out_push   (res_push),
    .out_result (res_wdata)
  );

  lrupr_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .wdata (res_wdata),
    .pop   (pop),
    .empty (empty),
    .rdata (res_head)
  );

  assign hit           = res_head.hit;
  assign frame_index   = res_head.frame_index;
  assign evicted_valid = res_head.evicted_valid;
  assign evicted_page  = res_head.evicted_page;
  assign hit_total     = res_head.hit_total;
  assign fault_total   = res_head.fault_total;

endmodule

### rtl/lrupr_checker.sv
// Port-level checks for lru_page_replacement, attached by the bind below.
// Depends on lrupr_pkg for the field widths.
module lrupr_checker
  import lrupr_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input logic [PAGE_W-1:0]  page,
  input logic               empty,
  input logic               pop,
  input logic               hit,
  input logic [IDX_W-1:0]   frame_index,
  input logic               evicted_valid,
  input logic [PAGE_W-1:0]  evicted_page,
  input logic [TOTAL_W-1:0] hit_total,
  input logic [TOTAL_W-1:0] fault_total
);

  // Reset flushes every queue, so no result can be shown right after it.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  // A hit never evicts a page.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(hit && evicted_valid))
    else $error("hit reported together with an eviction");

  // With no eviction the evicted page reads as zero.
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !evicted_valid) |-> (evicted_page == '0))
    else $error("evicted page nonzero without eviction");

  // Totals never go down from one transaction to the next.
  a_hit_mono: assert property (@(posedge clk) disable iff (rst)
    ($past(pop && !empty) && !empty && !$past(rst)) |->
      (hit_total >= $past(hit_total)))
    else $error("hit total went down");

  a_fault_mono: assert property (@(posedge clk) disable iff (rst)
    ($past(pop && !empty) && !empty && !$past(rst)) |->
      (fault_total >= $past(fault_total)))
    else $error("fault total went down");

endmodule

bind lru_page_replacement lrupr_checker u_checker (.*);
